/* rtl/tbpc_pkg.sv */
// Package for the two-button press/hold classifier.
// Holds the widths, codes and status struct shared by all files of the block.
// Depends on nothing.
package tbpc_pkg;

    // Widths of the fixed fields.
    localparam int THRESHOLD_WIDTH = 16;
    localparam int GESTURE_WIDTH   = 3;
    localparam int IGNORE_WIDTH    = 2;

    // Default width of the per-button hold counters.
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Hold threshold after reset.
    localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 16'd20;

    // Item operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WAKE   = 1'b1;

    // Gesture codes.
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_NONE       = 3'd0;
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_TOP_TAP    = 3'd1;
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_BOTTOM_TAP = 3'd2;
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_TOP_HOLD   = 3'd3;
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_BOTTOM_HOLD = 3'd4;
    localparam logic [GESTURE_WIDTH-1:0] GESTURE_BOTH_HOLD  = 3'd5;

    // Number of releases still to be swallowed.
    localparam logic [IGNORE_WIDTH-1:0] IGNORE_NONE = 2'd0;
    localparam logic [IGNORE_WIDTH-1:0] IGNORE_ONE  = 2'd1;
    localparam logic [IGNORE_WIDTH-1:0] IGNORE_TWO  = 2'd2;

    // Status of one button, as seen by the gesture logic.
    typedef struct packed {
        logic active;    // counter non-zero before this item
        logic released;  // button let go on this sample
        logic held;      // updated counter above the threshold
        logic is_zero;   // updated counter is zero
    } btn_status_t;

endpackage

/* rtl/tbpc_ifs.sv */
// Valid/ready channel interfaces of the two-button press/hold classifier.
// One carries button sample and wake items, the other gesture results.
// Depends on tbpc_pkg.
interface tbpc_in_if;
    logic valid;
    logic ready;
    logic op;
    logic top_pressed;
    logic bottom_pressed;

    modport source (output valid, output op, output top_pressed,
                    output bottom_pressed, input ready);
    modport sink (input valid, input op, input top_pressed,
                  input bottom_pressed, output ready);
endinterface

interface tbpc_out_if;
    logic                               valid;
    logic                               ready;
    logic [tbpc_pkg::GESTURE_WIDTH-1:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink (input valid, input gesture, output ready);
endinterface

/* rtl/tbpc_hold_counter.sv */
// Saturating hold counter of one button with release and hold detection.
// Updated once per accepted sample item.
// Depends on tbpc_pkg.
module tbpc_hold_counter #(
    parameter int COUNT_WIDTH = tbpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_en,
    input  logic                                 pressed,
    input  logic [tbpc_pkg::THRESHOLD_WIDTH-1:0] threshold,
    output tbpc_pkg::btn_status_t                status
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > tbpc_pkg::THRESHOLD_WIDTH) ?
                               COUNT_WIDTH : tbpc_pkg::THRESHOLD_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Count up while pressed, saturating; clear on release.
    always_comb
    begin
        if (pressed)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                count_next = count_reg;
            end
        end
        else
        begin
            count_next = '0;
        end
    end

    // Held and is_zero reflect the counter after this sample is applied; active and released the counter before it.
    always_comb
    begin
        status.active   = (count_reg != '0);
        status.released = !pressed && (count_reg != '0);
        status.held     = CMP_WIDTH'(count_next) > CMP_WIDTH'(threshold);
        status.is_zero  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (sample_en)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/tbpc_gesture_unit.sv */
// Gesture code and release-ignore state of the classifier.
// Applies one sample or wake item per enabled cycle.
// Depends on tbpc_pkg.
module tbpc_gesture_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_en,
    input  logic                               op,
    input  tbpc_pkg::btn_status_t              top_status,
    input  tbpc_pkg::btn_status_t              bottom_status,
    output logic [tbpc_pkg::GESTURE_WIDTH-1:0] gesture_next
);

    logic [tbpc_pkg::GESTURE_WIDTH-1:0] gesture_code_reg;
    logic [tbpc_pkg::IGNORE_WIDTH-1:0]  ignore_reg;
    logic [tbpc_pkg::IGNORE_WIDTH-1:0]  ignore_next;

    // Classify the item; the first matching rule wins.
    always_comb
    begin
        gesture_next = gesture_code_reg;
        ignore_next  = ignore_reg;
        if (op == tbpc_pkg::OP_SAMPLE)
        begin
            priority if (top_status.held && bottom_status.held)
            begin
                gesture_next = tbpc_pkg::GESTURE_BOTH_HOLD;
                ignore_next  = tbpc_pkg::IGNORE_TWO;
            end
            else if (bottom_status.held && top_status.is_zero)
            begin
                if (ignore_reg == tbpc_pkg::IGNORE_TWO)
                begin
                    gesture_next = tbpc_pkg::GESTURE_BOTH_HOLD;
                end
                else
                begin
                    gesture_next = tbpc_pkg::GESTURE_BOTTOM_HOLD;
                    ignore_next  = tbpc_pkg::IGNORE_ONE;
                end
            end
            else if (top_status.held && bottom_status.is_zero)
            begin
                if (ignore_reg == tbpc_pkg::IGNORE_TWO)
                begin
                    gesture_next = tbpc_pkg::GESTURE_BOTH_HOLD;
                end
                else
                begin
                    gesture_next = tbpc_pkg::GESTURE_TOP_HOLD;
                    ignore_next  = tbpc_pkg::IGNORE_ONE;
                end
            end
            else if (bottom_status.released)
            begin
                if (ignore_reg == tbpc_pkg::IGNORE_NONE)
                begin
                    gesture_next = tbpc_pkg::GESTURE_BOTTOM_TAP;
                end
                else
                begin
                    gesture_next = tbpc_pkg::GESTURE_NONE;
                    ignore_next  = tbpc_pkg::IGNORE_NONE;
                end
            end
            else if (top_status.released)
            begin
                if (ignore_reg == tbpc_pkg::IGNORE_NONE)
                begin
                    gesture_next = tbpc_pkg::GESTURE_TOP_TAP;
                end
                else
                begin
                    gesture_next = tbpc_pkg::GESTURE_NONE;
                    ignore_next  = tbpc_pkg::IGNORE_NONE;
                end
            end
            else
            begin
                gesture_next = gesture_code_reg;
            end
        end
        else
        begin
            // Wake: re-arm the ignore count from the buttons still down.
            // With only the bottom button down nothing changes.
            priority if (top_status.active && bottom_status.active)
            begin
                gesture_next = tbpc_pkg::GESTURE_NONE;
                ignore_next  = tbpc_pkg::IGNORE_TWO;
            end
            else if (top_status.active)
            begin
                gesture_next = tbpc_pkg::GESTURE_NONE;
                ignore_next  = tbpc_pkg::IGNORE_ONE;
            end
            else if (!bottom_status.active)
            begin
                gesture_next = tbpc_pkg::GESTURE_NONE;
                ignore_next  = tbpc_pkg::IGNORE_NONE;
            end
            else
            begin
                gesture_next = gesture_code_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gesture_code_reg <= tbpc_pkg::GESTURE_NONE;
            ignore_reg       <= tbpc_pkg::IGNORE_NONE;
        end
        else if (item_en)
        begin
            gesture_code_reg <= gesture_next;
            ignore_reg       <= ignore_next;
        end
    end

endmodule

/* rtl/two_button_press_hold_classifier_unit.sv */
// Two-button press/hold classifier. Each item is a sample of the two buttons
// or a wake event, and each item gives exactly one result: the gesture code
// after the item (0 none, 1/2 top/bottom tap, 3/4 top/bottom hold, 5 both
// held). The block takes one item per clock cycle while the result channel
// does not stall. An item passes the input register and then the result
// register before its result shows. The hold counters and gesture state
// close their loop combinationally, which is what allows an item in every
// cycle. The hold threshold is written through cfg_we/cfg_wdata by the user
// only while no item is in flight; the block itself does not enforce this.
// Depends on tbpc_pkg, tbpc_ifs, tbpc_hold_counter and tbpc_gesture_unit.
module two_button_press_hold_classifier_unit #(
    parameter int COUNT_WIDTH = tbpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tbpc_in_if.sink                              sample_ch,
    tbpc_out_if.source                           result_ch,
    input  logic                                 cfg_we,
    input  logic [tbpc_pkg::THRESHOLD_WIDTH-1:0] cfg_wdata
);

    logic [tbpc_pkg::THRESHOLD_WIDTH-1:0] hold_threshold_reg;

    logic stage_valid_reg;
    logic stage_op_reg;
    logic stage_top_reg;
    logic stage_bottom_reg;

    logic                               out_valid_reg;
    logic [tbpc_pkg::GESTURE_WIDTH-1:0] out_gesture_reg;

    logic                               advance;
    logic                               fire;
    logic                               sample_fire;
    logic                               accept;
    logic [tbpc_pkg::GESTURE_WIDTH-1:0] gesture_next;

    tbpc_pkg::btn_status_t top_status;
    tbpc_pkg::btn_status_t bottom_status;

    // Handshake: the staged item moves on when the result register is empty or its result is being taken.
    assign advance         = !out_valid_reg || result_ch.ready;
    assign fire            = stage_valid_reg && advance;
    assign sample_fire     = fire && (stage_op_reg == tbpc_pkg::OP_SAMPLE);
    assign sample_ch.ready = !stage_valid_reg || advance;
    assign accept          = sample_ch.valid && sample_ch.ready;

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.gesture = out_gesture_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_threshold_reg <= tbpc_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            hold_threshold_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg     <= sample_ch.op;
            stage_top_reg    <= sample_ch.top_pressed;
            stage_bottom_reg <= sample_ch.bottom_pressed;
        end
    end

    // Per-button hold counters.
    tbpc_hold_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_top_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_fire),
        .pressed   (stage_top_reg),
        .threshold (hold_threshold_reg),
        .status    (top_status)
    );

    tbpc_hold_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bottom_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_fire),
        .pressed   (stage_bottom_reg),
        .threshold (hold_threshold_reg),
        .status    (bottom_status)
    );

    // Gesture classification state.
    tbpc_gesture_unit u_gesture (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_en       (fire),
        .op            (stage_op_reg),
        .top_status    (top_status),
        .bottom_status (bottom_status),
        .gesture_next  (gesture_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_gesture_reg <= gesture_next;
        end
    end

endmodule

/* rtl/tbpc_checker.sv */
// Port-level checks of the two-button press/hold classifier, and the bind
// that attaches them to the top level.
// Depends on tbpc_pkg and two_button_press_hold_classifier_unit.
module tbpc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [tbpc_pkg::GESTURE_WIDTH-1:0] gesture
);

    // A result never carries a code beyond both-held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gesture <= tbpc_pkg::GESTURE_BOTH_HOLD))
    else $error("gesture code out of range");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(gesture)))
    else $error("stalled result changed");

    // A taken item whose result side is ready next cycle then reaches the result register as a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after accepted item");

    // With the result stalled, only one more item fits before input closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && in_valid && in_ready) ##1 !out_ready
        |-> !in_ready)
    else $error("item accepted with no room");

endmodule

bind two_button_press_hold_classifier_unit tbpc_checker u_tbpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .gesture   (result_ch.gesture)
);
